FILE: hdl/iso8601_duration_parser_top_macros.svh
`ifndef ISO8601_DURATION_PARSER_TOP_MACROS_SVH
`define ISO8601_DURATION_PARSER_TOP_MACROS_SVH

// Same-cycle implication check on the clock, off while reset is high.
`define IDP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("idp: same-cycle check failed");

// Next-cycle implication check on the clock, off while reset is high.
`define IDP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("idp: next-cycle check failed");

`endif

FILE: hdl/idp_pkg.sv
package idp_pkg;

   typedef enum logic [2:0] {
      PH_START,
      PH_MINUS,
      PH_TOKEN,
      PH_LEAD,
      PH_SIGNED,
      PH_DIGITS,
      PH_OK,
      PH_ERR
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_byte;
      logic       is_last;
   } idp_char_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Y     = 8'h59;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_S     = 8'h53;

   localparam logic [1:0]  MIN_LEN       = 2'd2;
   localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
   localparam logic [63:0] NANOS_PER_SEC = 64'd1000000000;

   localparam logic [63:0] ACC_CAP_POS = {1'b0, {63{1'b1}}};
   localparam logic [63:0] ACC_CAP_NEG = {1'b1, 63'd0};

   // Scaled images of the saturated magnitudes, modulo 2^64.
   localparam logic [63:0] SAT_POS_NANOS = 64'd0 - NANOS_PER_SEC;
   localparam logic [63:0] SAT_NEG_NANOS = 64'd0;

endpackage

FILE: hdl/iso8601_duration_parser_top.sv
// ISO 8601 duration parser: takes one character per transfer on req_ and
// returns one result on rsp_ for each string, on the character marked
// req_is_last. A new character is accepted every cycle while no last
// character waits on a stalled result register; a result moves from the input
// register through the parse logic into the result register. While an
// earlier result waits on rsp_stall, characters of the next string keep
// flowing up to its last character, which holds in the input register until
// the result register frees. The cycle is set by the 64-bit multiply-by-ten
// with saturation compare on the number accumulator; seconds are kept as a
// second, pre-scaled accumulator so nanos needs no wide multiply. On a syntax
// error every component, rsp_is_negative and rsp_ok read zero; a NUL
// character ends the string early.
module iso8601_duration_parser_top
   import idp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_years,
   output logic signed [31:0] rsp_months,
   output logic signed [31:0] rsp_days,
   output logic signed [31:0] rsp_hours,
   output logic signed [31:0] rsp_minutes,
   output logic signed [63:0] rsp_nanos,
   output logic               rsp_is_negative,
   output logic               rsp_ok
);

   idp_char_type item;
   logic         item_advance;
   logic [31:0]  years, months, days, hours, minutes;
   logic [63:0]  nanos;

   idp_input_reg u_input_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .req_is_last   (req_is_last),
      .item_advance  (item_advance),
      .item          (item)
   );

   idp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .item_advance    (item_advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_years       (years),
      .rsp_months      (months),
      .rsp_days        (days),
      .rsp_hours       (hours),
      .rsp_minutes     (minutes),
      .rsp_nanos       (nanos),
      .rsp_is_negative (rsp_is_negative),
      .rsp_ok          (rsp_ok)
   );

   assign rsp_years   = $signed(years);
   assign rsp_months  = $signed(months);
   assign rsp_days    = $signed(days);
   assign rsp_hours   = $signed(hours);
   assign rsp_minutes = $signed(minutes);
   assign rsp_nanos   = $signed(nanos);

endmodule

FILE: hdl/idp_input_reg.sv
module idp_input_reg
   import idp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_char_byte,
   input  logic         req_is_last,
   input  logic         item_advance,
   output idp_char_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       take;

   assign req_stall = valid_ff && !item_advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = 1'b1;
         char_in  = req_char_byte;
         last_in  = req_is_last;
      end else if (item_advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign item.valid     = valid_ff;
   assign item.char_byte = char_ff;
   assign item.is_last   = last_ff;

endmodule

FILE: hdl/idp_parser.sv
`include "iso8601_duration_parser_top_macros.svh"

module idp_parser
   import idp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  idp_char_type item,
   output logic         item_advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_years,
   output logic [31:0]  rsp_months,
   output logic [31:0]  rsp_days,
   output logic [31:0]  rsp_hours,
   output logic [31:0]  rsp_minutes,
   output logic [63:0]  rsp_nanos,
   output logic         rsp_is_negative,
   output logic         rsp_ok
);

   phase_type   phase_ff, phase_in;
   logic        time_ff, time_in;
   logic        neg_ff, neg_in;
   logic        nsign_ff, nsign_in;
   logic [63:0] accum_ff, accum_in;
   logic [63:0] scaled_ff, scaled_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] years_ff, years_in;
   logic [31:0] months_ff, months_in;
   logic [31:0] days_ff, days_in;
   logic [31:0] hours_ff, hours_in;
   logic [31:0] minutes_ff, minutes_in;
   logic [63:0] nanos_ff, nanos_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_years_ff, out_years_in;
   logic [31:0] out_months_ff, out_months_in;
   logic [31:0] out_days_ff, out_days_in;
   logic [31:0] out_hours_ff, out_hours_in;
   logic [31:0] out_minutes_ff, out_minutes_in;
   logic [63:0] out_nanos_ff, out_nanos_in;
   logic        out_neg_ff, out_neg_in;
   logic        out_ok_ff, out_ok_in;

   logic [7:0]  c;
   logic [3:0]  digit;
   logic        c_space, c_digit, live, bad;
   logic [63:0] digit_ns, value, svalue, cap;
   logic [67:0] acc_next;
   logic [63:0] scaled_next;
   phase_type   verdict;
   logic        out_zero, idle_state;

   function automatic phase_type end_verdict(input logic [1:0] cnt, input phase_type ph);
      phase_type v;
      begin
         v = PH_ERR;
         if (cnt >= MIN_LEN && (ph == PH_TOKEN || ph == PH_LEAD || ph == PH_SIGNED ||
                                ph == PH_OK)) begin
            v = PH_OK;
         end
         return v;
      end
   endfunction

   assign item_advance = item.valid && (!item.is_last || !out_valid_ff || !rsp_stall);

   assign c        = item.char_byte;
   assign digit    = c[3:0];
   assign c_space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign live     = (phase_ff != PH_OK) && (phase_ff != PH_ERR);
   assign digit_ns = 64'(digit) * NANOS_PER_SEC;
   assign cap      = nsign_ff ? ACC_CAP_NEG : ACC_CAP_POS;
   assign acc_next = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + 68'(digit);
   assign scaled_next = {scaled_ff[60:0], 3'b000} + {scaled_ff[62:0], 1'b0} + digit_ns;
   assign value    = nsign_ff ? (64'd0 - accum_ff) : accum_ff;
   assign svalue   = nsign_ff ? (64'd0 - scaled_ff) : scaled_ff;

   always_comb begin
      phase_in   = phase_ff;
      time_in    = time_ff;
      neg_in     = neg_ff;
      nsign_in   = nsign_ff;
      accum_in   = accum_ff;
      scaled_in  = scaled_ff;
      count_in   = count_ff;
      years_in   = years_ff;
      months_in  = months_ff;
      days_in    = days_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      nanos_in   = nanos_ff;
      bad        = 1'b0;
      verdict    = PH_ERR;

      out_valid_in   = out_valid_ff && rsp_stall;
      out_years_in   = out_years_ff;
      out_months_in  = out_months_ff;
      out_days_in    = out_days_ff;
      out_hours_in   = out_hours_ff;
      out_minutes_in = out_minutes_ff;
      out_nanos_in   = out_nanos_ff;
      out_neg_in     = out_neg_ff;
      out_ok_in      = out_ok_ff;

      if (item_advance) begin
         if (live) begin
            if (c == CH_NUL) begin
               phase_in = end_verdict(count_ff, phase_ff);
            end else begin
               if (count_ff < MIN_LEN) begin
                  count_in = count_ff + 2'd1;
               end
               case (phase_ff)
                  PH_START: begin
                     if (c == CH_MINUS) begin
                        neg_in   = 1'b1;
                        phase_in = PH_MINUS;
                     end else if (c == CH_P) begin
                        phase_in = PH_TOKEN;
                     end else begin
                        phase_in = PH_ERR;
                     end
                  end
                  PH_MINUS: begin
                     phase_in = (c == CH_P) ? PH_TOKEN : PH_ERR;
                  end
                  PH_TOKEN, PH_LEAD: begin
                     if (phase_ff == PH_TOKEN && c == CH_T) begin
                        time_in = 1'b1;
                     end else if (c_space) begin
                        phase_in = PH_LEAD;
                     end else if (c == CH_PLUS || c == CH_MINUS) begin
                        nsign_in = (c == CH_MINUS);
                        phase_in = PH_SIGNED;
                     end else if (c_digit) begin
                        accum_in  = 64'(digit);
                        scaled_in = digit_ns;
                        phase_in  = PH_DIGITS;
                     end else begin
                        phase_in = PH_OK;
                     end
                  end
                  PH_SIGNED: begin
                     if (c_digit) begin
                        accum_in  = 64'(digit);
                        scaled_in = digit_ns;
                        phase_in  = PH_DIGITS;
                     end else begin
                        phase_in = PH_OK;
                     end
                  end
                  PH_DIGITS: begin
                     if (c_digit) begin
                        // saturate as strtol does
                        if (acc_next > {4'd0, cap}) begin
                           accum_in  = cap;
                           scaled_in = nsign_ff ? SAT_NEG_NANOS : SAT_POS_NANOS;
                        end else begin
                           accum_in  = acc_next[63:0];
                           scaled_in = scaled_next;
                        end
                     end else begin
                        case (c)
                           CH_Y: begin
                              if (time_ff) bad = 1'b1;
                              else years_in = value[31:0];
                           end
                           CH_M: begin
                              if (time_ff) minutes_in = value[31:0];
                              else months_in = value[31:0];
                           end
                           CH_D: begin
                              if (time_ff) bad = 1'b1;
                              else days_in = value[31:0];
                           end
                           CH_W: begin
                              if (time_ff) bad = 1'b1;
                              else days_in = value[31:0] * DAYS_PER_WEEK;
                           end
                           CH_H: begin
                              if (!time_ff) bad = 1'b1;
                              else hours_in = value[31:0];
                           end
                           CH_S: begin
                              if (!time_ff) bad = 1'b1;
                              else nanos_in = svalue;
                           end
                           default: bad = 1'b1;
                        endcase
                        accum_in  = 64'd0;
                        scaled_in = 64'd0;
                        nsign_in  = 1'b0;
                        phase_in  = bad ? PH_ERR : PH_TOKEN;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end

         if (item.is_last) begin
            verdict = (phase_in == PH_OK || phase_in == PH_ERR) ? phase_in :
                      end_verdict(count_in, phase_in);
            out_valid_in = 1'b1;
            out_ok_in    = (verdict == PH_OK);
            if (verdict == PH_OK) begin
               out_years_in   = years_in;
               out_months_in  = months_in;
               out_days_in    = days_in;
               out_hours_in   = hours_in;
               out_minutes_in = minutes_in;
               out_nanos_in   = nanos_in;
               out_neg_in     = neg_in;
            end else begin
               out_years_in   = 32'd0;
               out_months_in  = 32'd0;
               out_days_in    = 32'd0;
               out_hours_in   = 32'd0;
               out_minutes_in = 32'd0;
               out_nanos_in   = 64'd0;
               out_neg_in     = 1'b0;
            end
            // restart for the next string
            phase_in   = PH_START;
            time_in    = 1'b0;
            neg_in     = 1'b0;
            nsign_in   = 1'b0;
            accum_in   = 64'd0;
            scaled_in  = 64'd0;
            count_in   = 2'd0;
            years_in   = 32'd0;
            months_in  = 32'd0;
            days_in    = 32'd0;
            hours_in   = 32'd0;
            minutes_in = 32'd0;
            nanos_in   = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         time_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         nsign_ff     <= 1'b0;
         accum_ff     <= 64'd0;
         scaled_ff    <= 64'd0;
         count_ff     <= 2'd0;
         years_ff     <= 32'd0;
         months_ff    <= 32'd0;
         days_ff      <= 32'd0;
         hours_ff     <= 32'd0;
         minutes_ff   <= 32'd0;
         nanos_ff     <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         time_ff      <= time_in;
         neg_ff       <= neg_in;
         nsign_ff     <= nsign_in;
         accum_ff     <= accum_in;
         scaled_ff    <= scaled_in;
         count_ff     <= count_in;
         years_ff     <= years_in;
         months_ff    <= months_in;
         days_ff      <= days_in;
         hours_ff     <= hours_in;
         minutes_ff   <= minutes_in;
         nanos_ff     <= nanos_in;
         out_valid_ff <= out_valid_in;
      end
      out_years_ff   <= out_years_in;
      out_months_ff  <= out_months_in;
      out_days_ff    <= out_days_in;
      out_hours_ff   <= out_hours_in;
      out_minutes_ff <= out_minutes_in;
      out_nanos_ff   <= out_nanos_in;
      out_neg_ff     <= out_neg_in;
      out_ok_ff      <= out_ok_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_years       = out_years_ff;
   assign rsp_months      = out_months_ff;
   assign rsp_days        = out_days_ff;
   assign rsp_hours       = out_hours_ff;
   assign rsp_minutes     = out_minutes_ff;
   assign rsp_nanos       = out_nanos_ff;
   assign rsp_is_negative = out_neg_ff;
   assign rsp_ok          = out_ok_ff;

   assign out_zero   = (out_years_ff == 32'd0) && (out_months_ff == 32'd0) &&
                       (out_days_ff == 32'd0) && (out_hours_ff == 32'd0) &&
                       (out_minutes_ff == 32'd0) && (out_nanos_ff == 64'd0) && !out_neg_ff;
   assign idle_state = (phase_ff == PH_START) && (count_ff == 2'd0);

   `IDP_ASSERT_NOW(a_err_zero, out_valid_ff && !out_ok_ff, out_zero)
   `IDP_ASSERT_NEXT(a_last_loads, item_advance && item.is_last, out_valid_ff && idle_state)
   `IDP_ASSERT_NOW(a_count_sat, 1'b1, count_ff <= MIN_LEN)
   `IDP_ASSERT_NOW(a_accum_cap, 1'b1, !accum_ff[63] || accum_ff[62:0] == 63'd0)
   `IDP_ASSERT_NOW(a_done_clean, phase_ff == PH_OK, accum_ff == 64'd0 && scaled_ff == 64'd0)

endmodule

FILE: test/testbench.sv
module testbench;
   import idp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   typedef struct packed {
      logic signed [31:0] years;
      logic signed [31:0] months;
      logic signed [31:0] days;
      logic signed [31:0] hours;
      logic signed [31:0] minutes;
      logic signed [63:0] nanos;
      logic               negative;
      logic               ok;
   } duration_rec_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_byte = 8'h00;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_years;
   logic signed [31:0] rsp_months;
   logic signed [31:0] rsp_days;
   logic signed [31:0] rsp_hours;
   logic signed [31:0] rsp_minutes;
   logic signed [63:0] rsp_nanos;
   logic               rsp_is_negative;
   logic               rsp_ok;

   iso8601_duration_parser_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_byte   (req_char_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_years       (rsp_years),
      .rsp_months      (rsp_months),
      .rsp_days        (rsp_days),
      .rsp_hours       (rsp_hours),
      .rsp_minutes     (rsp_minutes),
      .rsp_nanos       (rsp_nanos),
      .rsp_is_negative (rsp_is_negative),
      .rsp_ok          (rsp_ok)
   );

   text_char_type    char_queue[$];
   duration_rec_type expected_durations[$];
   logic [7:0]       text_buf[$];
   int               chars_queued = 0;
   int               error_count = 0;

   // parser state
   phase_type   parse_phase = PH_START;
   logic        in_time = 1'b0;
   logic        neg_duration = 1'b0;
   logic        num_minus = 1'b0;
   logic [63:0] accum = '0;
   logic [1:0]  char_count = '0;
   logic [31:0] part_vals[5] = '{default: '0};
   logic [63:0] nanos_val = '0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic phase_type close_phase();
      if (char_count < MIN_LEN)
         return PH_ERR;
      if (parse_phase == PH_TOKEN || parse_phase == PH_LEAD ||
          parse_phase == PH_SIGNED || parse_phase == PH_OK)
         return PH_OK;
      return PH_ERR;
   endfunction

   task automatic open_number(input logic [7:0] c);
      if (is_blank(c)) begin
         parse_phase = PH_LEAD;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         num_minus = (c == CH_MINUS);
         parse_phase = PH_SIGNED;
      end else if (is_numeral(c)) begin
         accum = 64'(c - CH_ZERO);
         parse_phase = PH_DIGITS;
      end else begin
         parse_phase = PH_OK;
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input logic last);
      duration_rec_type r;
      phase_type        verdict;
      logic [63:0]      value;
      logic [63:0]      cap;
      logic [63:0]      d;
      logic             bad;
      if (parse_phase != PH_OK && parse_phase != PH_ERR) begin
         if (c == CH_NUL) begin
            parse_phase = close_phase();
         end else begin
            if (char_count < MIN_LEN)
               char_count = char_count + 2'd1;
            case (parse_phase)
               PH_START: begin
                  if (c == CH_MINUS) begin
                     neg_duration = 1'b1;
                     parse_phase = PH_MINUS;
                  end else if (c == CH_P) begin
                     parse_phase = PH_TOKEN;
                  end else begin
                     parse_phase = PH_ERR;
                  end
               end
               PH_MINUS: parse_phase = (c == CH_P) ? PH_TOKEN : PH_ERR;
               PH_TOKEN: begin
                  if (c == CH_T)
                     in_time = 1'b1;
                  else
                     open_number(c);
               end
               PH_LEAD: open_number(c);
               PH_SIGNED: begin
                  if (is_numeral(c)) begin
                     accum = 64'(c - CH_ZERO);
                     parse_phase = PH_DIGITS;
                  end else begin
                     parse_phase = PH_OK;
                  end
               end
               PH_DIGITS: begin
                  if (is_numeral(c)) begin
                     d = 64'(c - CH_ZERO);
                     cap = num_minus ? ACC_CAP_NEG : ACC_CAP_POS;
                     if (accum > (cap - d) / 64'd10)
                        accum = cap;
                     else
                        accum = accum * 64'd10 + d;
                  end else begin
                     value = num_minus ? 64'd0 - accum : accum;
                     bad = 1'b0;
                     case (c)
                        CH_Y: if (in_time) bad = 1'b1; else part_vals[0] = value[31:0];
                        CH_M: if (in_time) part_vals[4] = value[31:0];
                              else part_vals[1] = value[31:0];
                        CH_D: if (in_time) bad = 1'b1; else part_vals[2] = value[31:0];
                        CH_W: if (in_time) bad = 1'b1;
                              else part_vals[2] = 32'(value * 64'(DAYS_PER_WEEK));
                        CH_H: if (!in_time) bad = 1'b1; else part_vals[3] = value[31:0];
                        CH_S: if (!in_time) bad = 1'b1; else nanos_val = value * NANOS_PER_SEC;
                        default: bad = 1'b1;
                     endcase
                     accum = '0;
                     num_minus = 1'b0;
                     parse_phase = bad ? PH_ERR : PH_TOKEN;
                  end
               end
               default: ;
            endcase
         end
      end
      if (last) begin
         verdict = (parse_phase == PH_OK || parse_phase == PH_ERR) ? parse_phase
                                                                   : close_phase();
         r = '0;
         if (verdict == PH_OK) begin
            r.years = part_vals[0];
            r.months = part_vals[1];
            r.days = part_vals[2];
            r.hours = part_vals[3];
            r.minutes = part_vals[4];
            r.nanos = nanos_val;
            r.negative = neg_duration;
            r.ok = 1'b1;
         end
         expected_durations.push_back(r);
         parse_phase = PH_START;
         in_time = 1'b0;
         neg_duration = 1'b0;
         num_minus = 1'b0;
         accum = '0;
         char_count = '0;
         part_vals = '{default: '0};
         nanos_val = '0;
      end
   endtask

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 50)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s mismatch: got %h, expected %h", name, got, want));
   endtask

   // stimulus
   task automatic flush_text();
      text_char_type t;
      foreach (text_buf[i]) begin
         t.ch = text_buf[i];
         t.last = (i == text_buf.size() - 1);
         char_queue.push_back(t);
         chars_queued++;
      end
      text_buf.delete();
   endtask

   // '#' stands for a NUL byte and '@' for 8'hFF in directed strings
   task automatic put_text(input string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c == "#")
            c = CH_NUL;
         else if (c == "@")
            c = 8'hFF;
         text_buf.push_back(c);
      end
      flush_text();
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   task automatic random_duration();
      int          tokens;
      int          n;
      int          w;
      logic        gen_time;
      logic [7:0]  date_units[4];
      logic [7:0]  time_units[3];
      date_units = '{CH_Y, CH_M, CH_D, CH_W};
      time_units = '{CH_H, CH_M, CH_S};
      if ($urandom_range(0, 9) < 8) begin
         gen_time = 1'b0;
         if ($urandom_range(0, 3) == 0)
            text_buf.push_back(CH_MINUS);
         text_buf.push_back(($urandom_range(0, 19) == 0) ? rand_byte() : CH_P);
         tokens = $urandom_range(0, 5);
         for (int k = 0; k < tokens; k++) begin
            if (!gen_time && $urandom_range(0, 3) == 0) begin
               text_buf.push_back(CH_T);
               gen_time = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
               w = $urandom_range(9, 14);
               text_buf.push_back((w == 14) ? CH_SPACE : 8'(w));
            end
            case ($urandom_range(0, 7))
               0: text_buf.push_back(CH_PLUS);
               1: text_buf.push_back(CH_MINUS);
               default: ;
            endcase
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
            repeat (n) text_buf.push_back(rand_digit());
            if ($urandom_range(0, 15) == 0)
               text_buf.push_back(rand_byte());
            else if (gen_time ^ ($urandom_range(0, 19) == 0))
               text_buf.push_back(time_units[$urandom_range(0, 2)]);
            else
               text_buf.push_back(date_units[$urandom_range(0, 3)]);
         end
         case ($urandom_range(0, 15))
            0: repeat ($urandom_range(1, 3)) text_buf.push_back(rand_digit());
            1: begin
               text_buf.push_back(CH_NUL);
               repeat ($urandom_range(0, 4)) text_buf.push_back(rand_byte());
            end
            2: repeat ($urandom_range(1, 4)) text_buf.push_back(rand_byte());
            default: ;
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(rand_byte());
      end
      flush_text();
   endtask

   initial begin
      put_text("P1Y");
      put_text("-P1Y2M3DT4H5M6S");
      put_text("P3W");
      put_text("P999999999999W");
      put_text("PT1.5S");
      put_text("P");
      put_text("P1");
      put_text("PX9Y");
      put_text("P \t\r+7D");
      put_text("P-D");
      put_text("PT");
      put_text("P1H");
      put_text("PT1D");
      put_text("P99999999999999999999Y");
      put_text("PT-99999999999999999999S");
      put_text("PT-9223372036854775808S");
      put_text("P1Y#zz");
      put_text("#P1Y");
      put_text("P#");
      put_text("Q1Y");
      put_text("-X");
      put_text("P1@");
      put_text("P@");
      put_text("PTT5M1M");
      put_text("P1Y1YT-0H");
      chars_queued = 0;
      while (chars_queued < 2000)
         random_duration();
   end

   // driver
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_char_byte <= 8'h00;
         req_is_last <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            void'(char_queue.pop_front());
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_char_byte <= char_queue[0].ch;
            req_is_last <= char_queue[0].last;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back up the block
   int             stall_cycle = 0;
   int             hold_left = 0;
   int             seg_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycle++;
         if (stall_cycle == 1500)
            hold_left = 400;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (stall_mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
               STALL_EVERY_THIRD: rsp_stall <= (stall_cycle % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // monitor
   duration_rec_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            parse_char(req_char_byte, req_is_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_durations.size() == 0) begin
               report_error("result transfer with no expected duration");
            end else begin
               want = expected_durations.pop_front();
               check_field("years", 64'(rsp_years), 64'(want.years));
               check_field("months", 64'(rsp_months), 64'(want.months));
               check_field("days", 64'(rsp_days), 64'(want.days));
               check_field("hours", 64'(rsp_hours), 64'(want.hours));
               check_field("minutes", 64'(rsp_minutes), 64'(want.minutes));
               check_field("nanos", rsp_nanos, want.nanos);
               check_field("is_negative", 64'(rsp_is_negative), 64'(want.negative));
               check_field("ok", 64'(rsp_ok), 64'(want.ok));
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      while (char_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_durations.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("PASS iso8601_duration_parser_top");
      else
         $display("FAIL iso8601_duration_parser_top");
      $finish;
   end

   initial begin
      #1000000;
      $display("FAIL iso8601_duration_parser_top");
      $finish;
   end

endmodule
